### rtl/led_pbe_pkg.sv
// Shared types and constants for the LED pixel buffer encoder.
// Used by the front, the job queue, the back and the top level.
`timescale 1ns / 1ps
package led_pbe_pkg;

  localparam int AddrW    = 15;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam int CntW     = 5;

  // Strip type codes
  localparam logic [2:0] TYPE_WS2801  = 3'd0;
  localparam logic [2:0] TYPE_APA102  = 3'd1;
  localparam logic [2:0] TYPE_WS2811  = 3'd2;
  localparam logic [2:0] TYPE_UCS2903 = 3'd3;
  localparam logic [2:0] TYPE_UCS1903 = 3'd4;
  localparam logic [2:0] TYPE_SK6812W = 3'd5;
  localparam logic [2:0] TYPE_GRB     = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LED_TYPE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_CODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LED_COUNT  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [2:0]          RST_LED_TYPE   = TYPE_GRB;
  localparam logic [7:0]          RST_HIGH_CODE  = 8'd248;
  localparam logic [7:0]          RST_BRIGHTNESS = 8'd255;
  localparam logic [CfgDataW-1:0] RST_LED_COUNT  = 11'd1024;

  // Byte codes
  localparam logic [7:0] LOW_CODE      = 8'hC0;
  localparam logic [7:0] BRIGHT_MAX    = 8'h1F;
  localparam logic [7:0] BRIGHT_PREFIX = 8'hE0;
  localparam logic [7:0] BRIGHT_FULL   = 8'hFF;
  localparam logic [AddrW-1:0] APA_OFFSET = 15'd4;

  // Last byte number of each layout
  localparam logic [CntW-1:0] CNT_ERR    = 5'd0;
  localparam logic [CntW-1:0] CNT_RAW3   = 5'd2;
  localparam logic [CntW-1:0] CNT_RAW4   = 5'd3;
  localparam logic [CntW-1:0] CNT_EXP3   = 5'd23;
  localparam logic [CntW-1:0] CNT_EXP4   = 5'd31;

  // One classified colour write, as the back part carries it out
  typedef struct packed {
    logic                  err;
    logic                  expand;
    logic [CntW-1:0]       cnt;
    logic [AddrW-1:0]      base;
    logic [3:0][7:0]       chan;
    logic [7:0]            high;
  } job_t;

endpackage

### rtl/led_pbe_front.sv
// Front part: configuration registers, intake of colour writes, classification.
// Depends on led_pbe_pkg; feeds the job queue.
`timescale 1ns / 1ps
module led_pbe_front
  import led_pbe_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                push,
  output logic                full,
  input  logic [9:0]          led_index,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          white,
  input  logic                queue_full,
  output logic                job_wr,
  output job_t                job
);

  logic [2:0]          led_type;
  logic [7:0]          high_code;
  logic [7:0]          global_brightness;
  logic [CfgDataW-1:0] led_count;

  logic                in_range;
  logic [7:0]          bright_code;
  logic [AddrW-1:0]    idx;

  // Take configuration words at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_type          <= RST_LED_TYPE;
      high_code         <= RST_HIGH_CODE;
      global_brightness <= RST_BRIGHTNESS;
      led_count         <= RST_LED_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LED_TYPE:   led_type          <= cfg_data[2:0];
        CFG_HIGH_CODE:  high_code         <= cfg_data[7:0];
        CFG_BRIGHTNESS: global_brightness <= cfg_data[7:0];
        CFG_LED_COUNT:  led_count         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a word whenever the queue has room
  assign full   = queue_full;
  assign job_wr = push && !queue_full;

  // Check the index against the count, saturated to the capacity
  assign in_range = ({1'b0, led_index} < led_count) && (32'(led_index) < MAX_LEDS);

  assign bright_code = (global_brightness > BRIGHT_MAX) ? BRIGHT_FULL
                     : (BRIGHT_PREFIX | (global_brightness & BRIGHT_MAX));

  assign idx = AddrW'(led_index);

  // Classify: pick layout, base address and channel order
  always_comb begin
    job        = '0;
    job.high   = high_code;
    if (!in_range) begin
      job.err = 1'b1;
      job.cnt = CNT_ERR;
    end else begin
      unique case (led_type) inside
        TYPE_APA102: begin
          job.cnt  = CNT_RAW4;
          job.base = APA_OFFSET + (idx << 2);
          job.chan = {blue, green, red, bright_code};
        end
        TYPE_WS2801: begin
          job.cnt  = CNT_RAW3;
          job.base = (idx << 1) + idx;
          job.chan = {8'd0, blue, green, red};
        end
        TYPE_WS2811, TYPE_UCS2903: begin
          job.expand = 1'b1;
          job.cnt    = CNT_EXP3;
          job.base   = (idx << 4) + (idx << 3);
          job.chan   = {8'd0, blue, green, red};
        end
        TYPE_UCS1903: begin
          job.expand = 1'b1;
          job.cnt    = CNT_EXP3;
          job.base   = (idx << 4) + (idx << 3);
          job.chan   = {8'd0, green, red, blue};
        end
        TYPE_SK6812W: begin
          job.expand = 1'b1;
          job.cnt    = CNT_EXP4;
          job.base   = idx << 5;
          job.chan   = {white, blue, red, green};
        end
        default: begin
          job.expand = 1'b1;
          job.cnt    = CNT_EXP3;
          job.base   = (idx << 4) + (idx << 3);
          job.chan   = {8'd0, blue, red, green};
        end
      endcase
    end
  end

endmodule

### rtl/led_pbe_fifo.sv
// Short job queue between the front and the back parts.
// Depends on led_pbe_pkg for the job record.
`timescale 1ns / 1ps
module led_pbe_fifo
  import led_pbe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output job_t rd_data,
  output logic q_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntQW = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntQW-1:0] fill;

  assign q_full  = (fill == CntQW'(DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = mem[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  wr_not_full: assert property (@(posedge clk) disable iff (rst) wr_en |-> !q_full)
    else $error("job queue written while full");
  rd_not_empty: assert property (@(posedge clk) disable iff (rst) rd_en |-> !q_empty)
    else $error("job queue read while empty");
  fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CntQW'(DEPTH))
    else $error("job queue fill level out of range");

endmodule

### rtl/led_pbe_back.sv
// Back part: steps through each job one byte a cycle into the result register, unless pop stalls it.
// Depends on led_pbe_pkg; reads the job queue.
`timescale 1ns / 1ps
module led_pbe_back
  import led_pbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic [AddrW-1:0]  byte_address,
  output logic [7:0]        byte_value,
  output logic              index_error,
  output logic              last
);

  job_t            cur;
  logic            cur_valid;
  logic [CntW-1:0] k;
  logic            out_valid;

  logic            load;
  logic            step;
  logic            last_k;
  logic            bit_one;
  logic [7:0]      value;

  assign empty  = !out_valid;
  assign load   = !out_valid || pop;
  assign step   = cur_valid && load;
  assign last_k = (k == cur.cnt);

  // Fetch the next job when idle or on the last byte of the current one
  assign q_rd = !q_empty && (!cur_valid || (step && last_k));

  // Pick the byte for the current step
  assign bit_one = cur.chan[k[4:3]][3'd7 - k[2:0]];
  assign value   = cur.expand ? (bit_one ? cur.high : LOW_CODE) : cur.chan[k[1:0]];

  // Hold the current job and its byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      k         <= '0;
    end else if (step && last_k) begin
      cur_valid <= 1'b0;
    end else if (step) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  // Result register: refill when free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_address <= cur.base + AddrW'(k);
      byte_value   <= value;
      index_error  <= cur.err;
      last         <= last_k;
    end
  end

  err_is_last: assert property (@(posedge clk) disable iff (rst)
      (!empty && index_error) |-> last)
    else $error("error result not marked last");
  k_in_range: assert property (@(posedge clk) disable iff (rst) cur_valid |-> (k <= cur.cnt))
    else $error("byte counter ran past the job");
  job_continues: assert property (@(posedge clk) disable iff (rst)
      (step && !last_k) |=> (cur_valid && k == $past(k) + 1'b1))
    else $error("job dropped before its last byte");

endmodule

### rtl/led_pixel_buffer_encoder_unit.sv
// LED pixel buffer encoder: taken words pass the job queue, job register and result register.
// Each word yields one result per cycle unless pop stalls: 1 (index error), 3 (WS2801),
// 4 (APA102), 24 (bit-expanded RGB types) or 32 (SK6812W); the back sequencer sets the rate.
// Input is taken back to back while the two-entry job queue has room.
// Synchronous active-high reset empties the queue and restores register defaults.
`timescale 1ns / 1ps
module led_pixel_buffer_encoder_unit
  import led_pbe_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                push,
  output logic                full,
  input  logic [9:0]          led_index,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          white,
  input  logic                pop,
  output logic                empty,
  output logic [AddrW-1:0]    byte_address,
  output logic [7:0]          byte_value,
  output logic                index_error,
  output logic                last
);

  logic queue_full;
  logic queue_empty;
  logic job_wr;
  logic job_rd;
  job_t job_in;
  job_t job_out;

  // Classify incoming words
  led_pbe_front #(.MAX_LEDS(MAX_LEDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .white      (white),
    .queue_full (queue_full),
    .job_wr     (job_wr),
    .job        (job_in)
  );

  // Decouple intake from byte generation
  led_pbe_fifo #(.DEPTH(2)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_wr),
    .wr_data (job_in),
    .q_full  (queue_full),
    .rd_en   (job_rd),
    .rd_data (job_out),
    .q_empty (queue_empty)
  );

  // Emit buffer byte writes
  led_pbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (queue_empty),
    .q_data       (job_out),
    .q_rd         (job_rd),
    .pop          (pop),
    .empty        (empty),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .index_error  (index_error),
    .last         (last)
  );

endmodule

### dv/tb_led_pixel_buffer_encoder_unit.sv
// Self-checking testbench for led_pixel_buffer_encoder_unit.
// Predicts every buffer byte word per colour write and checks it against the block.
// Depends on rtl/led_pbe_pkg.sv and rtl/led_pixel_buffer_encoder_unit.sv.
`timescale 1ns / 1ps
module tb_led_pixel_buffer_encoder_unit;
  import led_pbe_pkg::*;

  localparam int         MAX_LEDS     = 1024;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         TAIL_CYCLES  = 8;

  typedef struct {
    logic [9:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } pixel_t;

  typedef struct {
    logic [AddrW-1:0] byte_address;
    logic [7:0]       byte_value;
    logic             index_error;
    logic             last;
  } byte_write_t;

  // Predicts the buffer writes of each accepted colour write and checks results
  class pixel_write_checker;
    logic [2:0]          strip_type;
    logic [7:0]          one_code;
    logic [7:0]          brightness;
    logic [CfgDataW-1:0] count;
    byte_write_t         pending_writes[$];
    int                  errors;

    function new();
      strip_type = RST_LED_TYPE;
      one_code   = RST_HIGH_CODE;
      brightness = RST_BRIGHTNESS;
      count      = RST_LED_COUNT;
      errors     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_LED_TYPE:   strip_type = data[2:0];
        CFG_HIGH_CODE:  one_code   = data[7:0];
        CFG_BRIGHTNESS: brightness = data[7:0];
        CFG_LED_COUNT:  count      = data;
        default: ;
      endcase
    endfunction

    // Saturate the configured count at the strip capacity
    function int usable_leds();
      return (int'(count) > MAX_LEDS) ? MAX_LEDS : int'(count);
    endfunction

    function void add_write(int addr, logic [7:0] value, logic err, logic fin);
      byte_write_t w;
      w.byte_address = addr[AddrW-1:0];
      w.byte_value   = value;
      w.index_error  = err;
      w.last         = fin;
      pending_writes.push_back(w);
    endfunction

    function void note_pixel(pixel_t p);
      logic [7:0] chan [4];
      logic [7:0] level;
      int         nchan;
      int         base;
      int         idx;
      bit         bit_expand;
      idx = int'(p.led_index);
      // Reject an index at or beyond the strip length: one error word, no write
      if (idx >= usable_leds()) begin
        add_write(0, 8'h00, 1'b1, 1'b1);
        return;
      end
      bit_expand = 1'b1;
      nchan      = 3;
      base       = idx * 24;
      chan[3]    = p.white;
      case (strip_type)
        TYPE_APA102: begin
          level = (brightness > BRIGHT_MAX) ? BRIGHT_FULL
                                            : (BRIGHT_PREFIX | (brightness & BRIGHT_MAX));
          bit_expand = 1'b0;
          nchan      = 4;
          base       = int'(APA_OFFSET) + idx * 4;
          chan[0] = level;  chan[1] = p.red;  chan[2] = p.green;  chan[3] = p.blue;
        end
        TYPE_WS2801: begin
          bit_expand = 1'b0;
          base       = idx * 3;
          chan[0] = p.red;  chan[1] = p.green;  chan[2] = p.blue;
        end
        TYPE_WS2811, TYPE_UCS2903: begin
          chan[0] = p.red;  chan[1] = p.green;  chan[2] = p.blue;
        end
        TYPE_UCS1903: begin
          chan[0] = p.blue;  chan[1] = p.red;  chan[2] = p.green;
        end
        TYPE_SK6812W: begin
          nchan = 4;
          base  = idx * 32;
          chan[0] = p.green;  chan[1] = p.red;  chan[2] = p.blue;
        end
        default: begin
          chan[0] = p.green;  chan[1] = p.red;  chan[2] = p.blue;
        end
      endcase
      // Emit channels in address order, one byte per bit MSB first when expanded
      for (int c = 0; c < nchan; c++) begin
        if (bit_expand) begin
          for (int b = 0; b < 8; b++)
            add_write(base + c * 8 + b, chan[c][7-b] ? one_code : LOW_CODE, 1'b0,
                      (c == nchan - 1) && (b == 7));
        end else begin
          add_write(base + c, chan[c], 1'b0, c == nchan - 1);
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_write(logic [AddrW-1:0] a, logic [7:0] v, logic e, logic l);
      byte_write_t w;
      if (pending_writes.size() == 0) begin
        $error("result word at address %0d with none expected", a);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      compare_field("byte_address", 32'(w.byte_address), 32'(a));
      compare_field("byte_value", 32'(w.byte_value), 32'(v));
      compare_field("index_error", 32'(w.index_error), 32'(e));
      compare_field("last", 32'(w.last), 32'(l));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                push = 1'b0;
  logic                full;
  logic [9:0]          led_index = '0;
  logic [7:0]          red = '0;
  logic [7:0]          green = '0;
  logic [7:0]          blue = '0;
  logic [7:0]          white = '0;
  logic                pop = 1'b0;
  logic                empty;
  logic [AddrW-1:0]    byte_address;
  logic [7:0]          byte_value;
  logic                index_error;
  logic                last;

  pixel_write_checker board;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  led_pixel_buffer_encoder_unit #(.MAX_LEDS(MAX_LEDS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .led_index    (led_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .white        (white),
    .pop          (pop),
    .empty        (empty),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .index_error  (index_error),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check each popped word, then pick the next pop with random stalls
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_write(byte_address, byte_value, index_error, last);
    if (hold_req) begin
      stall_left = HOLD_CYCLES;
      hold_req   = 1'b0;
    end else if (stall_left == 0 && !rx_fast && $urandom_range(0, 39) == 0) begin
      stall_left = $urandom_range(8, 40);
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= rx_fast ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drop push and hold until every predicted word has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (board.pending_writes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  task automatic configure(logic [2:0] strip, logic [7:0] one_code, logic [7:0] level,
                           logic [CfgDataW-1:0] count);
    wait_drained();
    write_reg(CFG_LED_TYPE, CfgDataW'(strip));
    write_reg(CFG_HIGH_CODE, CfgDataW'(one_code));
    write_reg(CFG_BRIGHTNESS, CfgDataW'(level));
    write_reg(CFG_LED_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(pixel_t p);
    push      <= 1'b1;
    led_index <= p.led_index;
    red       <= p.red;
    green     <= p.green;
    blue      <= p.blue;
    white     <= p.white;
    do @(posedge clk); while (full);
    board.note_pixel(p);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (tx_fast || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic drive(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                       logic [7:0] w);
    pixel_t p;
    p.led_index = idx[9:0];
    p.red       = r;
    p.green     = g;
    p.blue      = b;
    p.white     = w;
    send_pixel(p);
    pause(gap_len());
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly indexes in range, some anywhere so short strips reject them
  function automatic int random_index();
    int n;
    n = board.usable_leds();
    if (n == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 1023);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic run_phase(int n_items, bit hold_off);
    logic [2:0]          strip;
    logic [7:0]          one_code;
    logic [7:0]          level;
    logic [CfgDataW-1:0] count;
    strip = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       one_code = 8'h00;
      1:       one_code = 8'hFF;
      default: one_code = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       level = 8'($urandom_range(0, 31));
      1:       level = 8'($urandom_range(31, 32));
      default: level = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 6))
      0:       count = 11'd1;
      1:       count = 11'd1024;
      2:       count = 11'd2047;
      3:       count = 11'($urandom_range(1, 16));
      4:       count = 11'd0;
      default: count = 11'($urandom_range(1, 1024));
    endcase
    configure(strip, one_code, level, count);
    tx_fast = ($urandom_range(0, 3) == 0);
    rx_fast = ($urandom_range(0, 3) == 0);
    // Keep offering words while the receiver holds off, so the input stalls
    if (hold_off) begin
      tx_fast  = 1'b1;
      hold_req = 1'b1;
    end
    repeat (n_items)
      drive(random_index(), random_level(), random_level(), random_level(), random_level());
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every strip type, the undefined code too, at the lowest and highest index
    for (int t = 0; t < 8; t++) begin
      configure(3'(t), RST_HIGH_CODE, RST_BRIGHTNESS, RST_LED_COUNT);
      drive(0, 8'hFF, 8'h00, 8'hA5, 8'h5A);
      drive(1023, 8'h00, 8'hFF, 8'h5A, 8'hA5);
    end

    // Brightness encodings, one-LED strip with a rejected index
    configure(TYPE_APA102, 8'h00, 8'd0, 11'd1);
    drive(0, 8'h12, 8'h34, 8'h56, 8'h78);
    drive(1, 8'h12, 8'h34, 8'h56, 8'h78);
    // Empty strip rejects everything
    configure(TYPE_APA102, 8'hFF, 8'd31, 11'd0);
    drive(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Count above capacity saturates, brightness just over the limit
    configure(TYPE_APA102, 8'hFF, 8'd32, 11'd2047);
    drive(1023, 8'h81, 8'h42, 8'h24, 8'h18);
    // High code extremes in expanded layouts
    configure(TYPE_SK6812W, 8'h00, RST_BRIGHTNESS, RST_LED_COUNT);
    drive(512, 8'hF0, 8'h0F, 8'hCC, 8'h33);
    configure(TYPE_UCS1903, 8'hFF, RST_BRIGHTNESS, RST_LED_COUNT);
    drive(511, 8'h0F, 8'hF0, 8'h33, 8'hCC);

    for (int ph = 0; ph < 10; ph++)
      run_phase(21, ph == 2);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_writes.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
